@@ hw/rtl/fault_code_counter_store_top_macros.svh @@
// ----------------------------------------------------------------------------
// Fault code counter store assertion macros
// Shared concurrent assertion forms used by the top level.
// ----------------------------------------------------------------------------
`ifndef FAULT_CODE_COUNTER_STORE_TOP_MACROS_SVH
`define FAULT_CODE_COUNTER_STORE_TOP_MACROS_SVH

// Same-cycle implication, clocked on clk_i and disabled during reset.
`define FCCS_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, clocked on clk_i and disabled during reset.
`define FCCS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hw/rtl/fccs_pkg.sv @@
// ----------------------------------------------------------------------------
// Fault code counter store package
// Fixed field widths, operation codes, controller states and memory controls.
// ----------------------------------------------------------------------------
package fccs_pkg;

  localparam int unsigned MODE_W    = 3;
  localparam int unsigned IDX_IN_W  = 5;
  localparam int unsigned IDX_EXT_W = 9;
  localparam int unsigned CNT_W     = 8;
  localparam int unsigned WORD_W    = 2 * CNT_W;
  localparam int unsigned POS_W     = 6;

  typedef enum logic [MODE_W-1:0] {
    MODE_RECORD = 3'd0,
    MODE_SEEK   = 3'd1,
    MODE_QUERY  = 3'd2,
    MODE_CLEAR  = 3'd3,
    MODE_LOAD   = 3'd4,
    MODE_SAVE   = 3'd5
  } mode_e;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_EVAL = 1'b1
  } state_e;

  typedef struct packed {
    logic we;
    logic clr;
  } mem_ctl_t;

endpackage

@@ hw/rtl/fault_code_counter_store_top.sv @@
// Flow: record, query, clear, load, save and unused codes read their entry on
// acceptance and give their word from the evaluate state; seek reads the
// entries one by one, at most NUM_CODES, through the single memory read port.
// A new command is taken only while idle, so one word is in flight at a time.
// Reset: asynchronous; all counts read as zero at once, cursor idle, clean.
// The strobe done_o lasts one cycle and cannot be stalled.
// ----------------------------------------------------------------------------
// Fault code counter store top level
// Sequencer that reads, modifies and writes back the counter memory.
// ----------------------------------------------------------------------------
module fault_code_counter_store_top #(
  parameter int unsigned NUM_CODES = 32,
  parameter int unsigned COUNT_MAX = 255
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start,
  output logic                                 busy,
  input  logic [fccs_pkg::MODE_W-1:0]          mode_i,
  input  logic [fccs_pkg::IDX_IN_W-1:0]        code_index_i,
  input  logic [fccs_pkg::CNT_W-1:0]           stored_count_i,
  output logic                                 done_o,
  output logic                                 hit_o,
  output logic signed [fccs_pkg::POS_W-1:0]    position_o,
  output logic [fccs_pkg::CNT_W-1:0]           count_o,
  output logic                                 dirty_o
);
  import fccs_pkg::*;

  localparam int unsigned IDX_W = $clog2(NUM_CODES);
  localparam int unsigned PW    = (IDX_W > POS_W) ? IDX_W : POS_W;
  localparam logic [IDX_W-1:0] LAST = IDX_W'(NUM_CODES - 1);

  state_e             state_q, state_d;
  mode_e              mode_q, mode_d;
  logic [IDX_W-1:0]   addr_q, addr_d;
  logic               in_range_q, in_range_d;
  logic [CNT_W-1:0]   stored_q, stored_d;
  logic               cur_idle_q, cur_idle_d;
  logic [IDX_W-1:0]   cur_idx_q, cur_idx_d;
  logic               dirty_q, dirty_d;
  logic               done_q, done_d;
  logic               hit_q, hit_d;
  logic [CNT_W-1:0]   count_q, count_d;

  mem_ctl_t           mem_ctl;
  logic [IDX_W-1:0]   rd_addr;
  logic [WORD_W-1:0]  wdata;
  logic [WORD_W-1:0]  rdata;
  logic [CNT_W-1:0]   cur_cnt, sess_cnt;
  logic [IDX_EXT_W-1:0] idx_ext;
  logic               accept;
  logic [PW-1:0]      pos_ext;

  fccs_mem #(
    .NUM_CODES(NUM_CODES)
  ) u_mem (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctl_i    (mem_ctl),
    .rd_addr_i(rd_addr),
    .wr_addr_i(addr_q),
    .wdata_i  (wdata),
    .rdata_o  (rdata)
  );

  assign accept   = start && (state_q == ST_IDLE);
  assign idx_ext  = IDX_EXT_W'(code_index_i);
  assign cur_cnt  = rdata[CNT_W-1:0];
  assign sess_cnt = rdata[WORD_W-1:CNT_W];

  always_comb begin
    state_d    = state_q;
    mode_d     = mode_q;
    addr_d     = addr_q;
    in_range_d = in_range_q;
    stored_d   = stored_q;
    cur_idle_d = cur_idle_q;
    cur_idx_d  = cur_idx_q;
    dirty_d    = dirty_q;
    done_d     = 1'b0;
    hit_d      = hit_q;
    count_d    = count_q;
    mem_ctl    = '0;
    wdata      = rdata;
    rd_addr    = addr_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          mode_d     = mode_e'(mode_i);
          stored_d   = stored_count_i;
          in_range_d = idx_ext < IDX_EXT_W'(NUM_CODES);
          if (mode_e'(mode_i) == MODE_SEEK) begin
            addr_d = cur_idle_q ? '0 : IDX_W'(cur_idx_q + 1'b1);
          end else begin
            addr_d = idx_ext[IDX_W-1:0];
          end
          rd_addr = addr_d;
          if (mode_e'(mode_i) == MODE_SEEK && !cur_idle_q && cur_idx_q == LAST) begin
            // Cursor already on the last entry: nothing left to scan.
            cur_idle_d = 1'b1;
            hit_d      = 1'b0;
            count_d    = '0;
            done_d     = 1'b1;
          end else begin
            state_d = ST_EVAL;
          end
        end
      end
      ST_EVAL: begin
        hit_d   = 1'b0;
        count_d = in_range_q ? cur_cnt : '0;
        case (mode_q)
          MODE_RECORD: begin
            if (in_range_q && sess_cnt < CNT_W'(COUNT_MAX) && cur_cnt == sess_cnt) begin
              wdata      = {sess_cnt, CNT_W'(cur_cnt + 1'b1)};
              mem_ctl.we = 1'b1;
              dirty_d    = 1'b1;
              count_d    = CNT_W'(cur_cnt + 1'b1);
            end
          end
          MODE_SEEK: begin
            if (cur_cnt != '0) begin
              cur_idle_d = 1'b0;
              cur_idx_d  = addr_q;
              hit_d      = 1'b1;
              count_d    = cur_cnt;
            end else if (addr_q == LAST) begin
              cur_idle_d = 1'b1;
              count_d    = '0;
            end else begin
              addr_d  = IDX_W'(addr_q + 1'b1);
              rd_addr = addr_d;
            end
          end
          MODE_QUERY: begin
            hit_d = in_range_q && (cur_cnt != '0);
          end
          MODE_CLEAR: begin
            mem_ctl.clr = 1'b1;
            dirty_d     = 1'b1;
            count_d     = '0;
          end
          MODE_LOAD: begin
            if (in_range_q) begin
              wdata      = {stored_q, stored_q};
              mem_ctl.we = 1'b1;
              count_d    = stored_q;
            end
          end
          MODE_SAVE: begin
            dirty_d = 1'b0;
          end
          default: begin
          end
        endcase
        if (!(mode_q == MODE_SEEK && cur_cnt == '0 && addr_q != LAST)) begin
          state_d = ST_IDLE;
          done_d  = 1'b1;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      cur_idle_q <= 1'b1;
      cur_idx_q  <= '0;
      dirty_q    <= 1'b0;
      done_q     <= 1'b0;
    end else begin
      state_q    <= state_d;
      cur_idle_q <= cur_idle_d;
      cur_idx_q  <= cur_idx_d;
      dirty_q    <= dirty_d;
      done_q     <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mode_q     <= mode_d;
    addr_q     <= addr_d;
    in_range_q <= in_range_d;
    stored_q   <= stored_d;
    hit_q      <= hit_d;
    count_q    <= count_d;
  end

  assign pos_ext    = PW'(cur_idx_q);
  assign busy       = (state_q != ST_IDLE);
  assign done_o     = done_q;
  assign hit_o      = hit_q;
  assign position_o = cur_idle_q ? '1 : pos_ext[POS_W-1:0];
  assign count_o    = count_q;
  assign dirty_o    = dirty_q;

`include "fault_code_counter_store_top_macros.svh"

  `FCCS_ASSERT_SAME(a_done_when_idle, done_o, !busy, "Result word while busy.")
  `FCCS_ASSERT_NEXT(a_accept_progress, start && !busy, busy || done_o, "Accepted word lost.")
  `FCCS_ASSERT_SAME(a_hit_has_cursor, done_o && hit_o && (mode_q == MODE_SEEK), !cur_idle_q,
                    "Seek hit with idle cursor.")

endmodule

@@ hw/rtl/fccs_mem.sv @@
// ----------------------------------------------------------------------------
// Fault code counter memory
// One word per code holding the session count and the current count, with a
// registered read port and a valid bit per entry that reset and clear-all drop.
// ----------------------------------------------------------------------------
module fccs_mem #(
  parameter int unsigned NUM_CODES = 32
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  fccs_pkg::mem_ctl_t                   ctl_i,
  input  logic [$clog2(NUM_CODES)-1:0]         rd_addr_i,
  input  logic [$clog2(NUM_CODES)-1:0]         wr_addr_i,
  input  logic [fccs_pkg::WORD_W-1:0]          wdata_i,
  output logic [fccs_pkg::WORD_W-1:0]          rdata_o
);
  import fccs_pkg::*;

  logic [WORD_W-1:0]    mem_q [NUM_CODES];
  logic [NUM_CODES-1:0] vld_q;
  logic [WORD_W-1:0]    data_q;
  logic                 rd_vld_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.we) begin
      mem_q[wr_addr_i] <= wdata_i;
    end
    data_q <= mem_q[rd_addr_i];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      rd_vld_q <= vld_q[rd_addr_i];
      if (ctl_i.clr) begin
        vld_q <= '0;
      end else if (ctl_i.we) begin
        vld_q[wr_addr_i] <= 1'b1;
      end
    end
  end

  assign rdata_o = rd_vld_q ? data_q : '0;

endmodule

@@ tb/sv/fault_code_counter_store_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Fault code counter store checker
// Follows the command and result channels, keeps its own copy of both count
// tables, the cursor and the dirty mark, and compares every result word with
// the word predicted for the oldest accepted command.
// ----------------------------------------------------------------------------
module fault_code_counter_store_checker #(
  parameter int unsigned NUM_CODES = 32,
  parameter int unsigned COUNT_MAX = 255
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  input  logic                              busy_i,
  input  logic [fccs_pkg::MODE_W-1:0]       mode_i,
  input  logic [fccs_pkg::IDX_IN_W-1:0]     code_index_i,
  input  logic [fccs_pkg::CNT_W-1:0]        stored_count_i,
  input  logic                              done_i,
  input  logic                              hit_i,
  input  logic signed [fccs_pkg::POS_W-1:0] position_i,
  input  logic [fccs_pkg::CNT_W-1:0]        count_i,
  input  logic                              dirty_i,
  output int                                fail_count_o,
  output int                                pending_o
);
  import fccs_pkg::*;

  typedef struct packed {
    logic             hit;
    logic [POS_W-1:0] position;
    logic [CNT_W-1:0] count;
    logic             dirty;
  } fault_word_t;

  logic [CNT_W-1:0] live_counts [NUM_CODES];
  logic [CNT_W-1:0] boot_counts [NUM_CODES];
  int               seek_cursor;
  logic             unsaved;
  fault_word_t      due_words [$];
  fault_word_t      due;

  function automatic fault_word_t apply_command(logic [MODE_W-1:0] op,
                                                logic [IDX_IN_W-1:0] idx,
                                                logic [CNT_W-1:0] stored);
    fault_word_t word;
    logic        in_range;
    logic        found;
    in_range = idx < NUM_CODES;
    found    = 1'b0;
    word     = '0;
    case (op)
      MODE_RECORD: begin
        if (in_range && boot_counts[idx] < COUNT_MAX &&
            live_counts[idx] == boot_counts[idx]) begin
          live_counts[idx] = live_counts[idx] + 1'b1;
          unsaved          = 1'b1;
        end
      end
      MODE_SEEK: begin
        while (!found && seek_cursor < int'(NUM_CODES) - 1) begin
          seek_cursor++;
          if (live_counts[seek_cursor] != 0) found = 1'b1;
        end
        if (!found) seek_cursor = -1;
        word.hit = found;
      end
      MODE_QUERY: begin
        word.hit = in_range && live_counts[idx] != 0;
      end
      MODE_CLEAR: begin
        for (int i = 0; i < NUM_CODES; i++) begin
          live_counts[i] = '0;
          boot_counts[i] = '0;
        end
        unsaved = 1'b1;
      end
      MODE_LOAD: begin
        if (in_range) begin
          live_counts[idx] = stored;
          boot_counts[idx] = stored;
        end
      end
      MODE_SAVE: begin
        unsaved = 1'b0;
      end
      default: begin
      end
    endcase
    if (op == MODE_SEEK) begin
      word.count = (seek_cursor >= 0) ? live_counts[seek_cursor] : '0;
    end else begin
      word.count = in_range ? live_counts[idx] : '0;
    end
    word.position = seek_cursor[POS_W-1:0];
    word.dirty    = unsaved;
    return word;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_CODES; i++) begin
        live_counts[i] = '0;
        boot_counts[i] = '0;
      end
      seek_cursor = -1;
      unsaved     = 1'b0;
      due_words.delete();
      fail_count_o = 0;
      pending_o    = 0;
    end else begin
      if (done_i) begin
        if (due_words.size() == 0) begin
          $error("Unexpected word: hit %0b position %0d count %0d dirty %0b",
                 hit_i, position_i, count_i, dirty_i);
          fail_count_o++;
        end else begin
          due = due_words.pop_front();
          if (hit_i !== due.hit) begin
            $error("hit: expected %0b, actual %0b", due.hit, hit_i);
            fail_count_o++;
          end
          if (position_i !== due.position) begin
            $error("position: expected %0d, actual %0d",
                   $signed(due.position), position_i);
            fail_count_o++;
          end
          if (count_i !== due.count) begin
            $error("count: expected %0d, actual %0d", due.count, count_i);
            fail_count_o++;
          end
          if (dirty_i !== due.dirty) begin
            $error("dirty: expected %0b, actual %0b", due.dirty, dirty_i);
            fail_count_o++;
          end
        end
      end
      if (start_i && !busy_i) begin
        due_words.push_back(apply_command(mode_i, code_index_i, stored_count_i));
      end
      pending_o = due_words.size();
    end
  end

endmodule

@@ tb/sv/fault_code_counter_store_top_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Fault code counter store testbench
// Sends a directed set of commands and then a long random mix with random
// gaps into the counter store, and reports the verdict of the checker.
// ----------------------------------------------------------------------------
module fault_code_counter_store_top_tb;
  import fccs_pkg::*;

  localparam logic [MODE_W-1:0] MODE_SPARE_LO = 3'd6;
  localparam logic [MODE_W-1:0] MODE_SPARE_HI = 3'd7;
  localparam int unsigned       CYCLE_LIMIT   = 1_000_000;
  localparam int unsigned       DRAIN_CYCLES  = 40;
  localparam int unsigned       RANDOM_WORDS  = 1650;

  logic                      clk = 1'b0;
  logic                      rst_n = 1'b0;
  logic                      start = 1'b0;
  logic                      busy;
  logic [MODE_W-1:0]         mode = '0;
  logic [IDX_IN_W-1:0]       code_index = '0;
  logic [CNT_W-1:0]          stored_count = '0;
  logic                      done;
  logic                      hit;
  logic signed [POS_W-1:0]   position;
  logic [CNT_W-1:0]          count;
  logic                      dirty;
  int                        fail_count;
  int                        pending;
  int unsigned               cycle_count = 0;
  bit                        quiet_run = 1'b0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  fault_code_counter_store_top uut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .start          (start),
    .busy           (busy),
    .mode_i         (mode),
    .code_index_i   (code_index),
    .stored_count_i (stored_count),
    .done_o         (done),
    .hit_o          (hit),
    .position_o     (position),
    .count_o        (count),
    .dirty_o        (dirty)
  );

  fault_code_counter_store_checker checker_i (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .start_i        (start),
    .busy_i         (busy),
    .mode_i         (mode),
    .code_index_i   (code_index),
    .stored_count_i (stored_count),
    .done_i         (done),
    .hit_i          (hit),
    .position_i     (position),
    .count_i        (count),
    .dirty_i        (dirty),
    .fail_count_o   (fail_count),
    .pending_o      (pending)
  );

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("** fault_code_counter_store_top: FAILED **");
      $finish;
    end
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (quiet_run || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(11, 40);
  endfunction

  function automatic logic [CNT_W-1:0] pick_stored();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 15) return '0;
    if (r < 30) return 8'd255;
    if (r < 45) return 8'd254;
    return CNT_W'($urandom_range(0, 255));
  endfunction

  task automatic send_word(input logic [MODE_W-1:0] op, input logic [IDX_IN_W-1:0] idx,
                           input logic [CNT_W-1:0] stored);
    int unsigned gap;
    start        <= 1'b1;
    mode         <= op;
    code_index   <= idx;
    stored_count <= stored;
    do @(posedge clk); while (busy);
    @(negedge clk);
    gap = pick_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  initial begin
    int unsigned        sent;
    int unsigned        r;
    int unsigned        sweep;
    logic [MODE_W-1:0]  op;
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    send_word(MODE_SEEK,   5'd0,  8'h00);
    send_word(MODE_RECORD, 5'd0,  8'hFF);
    send_word(MODE_RECORD, 5'd0,  8'h00);
    send_word(MODE_RECORD, 5'd31, 8'hAA);
    send_word(MODE_QUERY,  5'd0,  8'h55);
    send_word(MODE_QUERY,  5'd31, 8'h00);
    send_word(MODE_QUERY,  5'd5,  8'h00);
    send_word(MODE_SEEK,   5'd0,  8'h00);
    send_word(MODE_LOAD,   5'd7,  8'd255);
    send_word(MODE_RECORD, 5'd7,  8'h00);
    send_word(MODE_LOAD,   5'd10, 8'd254);
    send_word(MODE_RECORD, 5'd10, 8'h00);
    send_word(MODE_RECORD, 5'd10, 8'h00);
    send_word(MODE_LOAD,   5'd3,  8'h55);
    send_word(MODE_SAVE,   5'd21, 8'hAA);
    send_word(MODE_SEEK,   5'd0,  8'h00);
    send_word(MODE_SEEK,   5'd0,  8'h00);
    send_word(MODE_SEEK,   5'd0,  8'h00);
    send_word(MODE_SEEK,   5'd0,  8'h00);
    send_word(MODE_SEEK,   5'd0,  8'h00);
    send_word(MODE_SPARE_LO, 5'd10, 8'hFF);
    send_word(MODE_SPARE_HI, 5'd31, 8'h00);
    send_word(MODE_CLEAR,  5'd0,  8'h00);
    send_word(MODE_SEEK,   5'd0,  8'h00);
    send_word(MODE_QUERY,  5'd10, 8'h00);

    sent = 0;
    while (sent < RANDOM_WORDS) begin
      if ($urandom_range(0, 49) == 0) quiet_run = !quiet_run;
      if ($urandom_range(0, 99) < 6) begin
        sweep = $urandom_range(3, 34);
        repeat (sweep) send_word(MODE_SEEK, IDX_IN_W'($urandom_range(0, 31)), pick_stored());
        sent += sweep;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 38)      op = MODE_RECORD;
        else if (r < 50) op = MODE_SEEK;
        else if (r < 64) op = MODE_QUERY;
        else if (r < 66) op = MODE_CLEAR;
        else if (r < 80) op = MODE_LOAD;
        else if (r < 88) op = MODE_SAVE;
        else if (r < 94) op = MODE_SPARE_LO;
        else             op = MODE_SPARE_HI;
        send_word(op, IDX_IN_W'($urandom_range(0, 31)), pick_stored());
        sent++;
      end
    end
    start <= 1'b0;

    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("** fault_code_counter_store_top: PASSED **");
    end else begin
      $display("** fault_code_counter_store_top: FAILED **");
    end
    $finish;
  end

endmodule
